// ===== sv/spcg_pkg.sv =====
// ----------------------------------------------------------------------------
// spcg_pkg
// Shared widths, side-band records and saturation helper for the sphere pair
// contact geometry pipeline.
// ----------------------------------------------------------------------------
package spcg_pkg;

	localparam int COORD_W  = 32;
	localparam int DIFF_W   = 33;
	localparam int RAD_W    = 31;
	localparam int FACTOR_W = 16;
	localparam int NORM_W   = 18;
	localparam int DSQ_W    = 66;
	localparam int ROOT_W   = 33;
	localparam int QUOT_W   = 17;

	localparam logic [FACTOR_W-1:0] FACTOR_RESET = 16'd4096;

	typedef struct packed {
		logic signed [2:0][COORD_W-1:0] p1;
		logic [2:0]                     dneg;
		logic [2:0][DIFF_W-1:0]         dmag;
		logic [RAD_W-1:0]               ra;
		logic [RAD_W-1:0]               rb;
		logic                           contact;
	} side_t;

	typedef struct packed {
		side_t             base;
		logic [ROOT_W-1:0] sep;
	} div_side_t;

	function automatic logic signed [COORD_W-1:0] sat32(input logic signed [39:0] v);
		logic signed [39:0] hi;
		logic signed [39:0] lo;
		hi = 40'sh007FFFFFFF;
		lo = -40'sh0080000000;
		if (v > hi)
			return 32'sh7FFFFFFF;
		else if (v < lo)
			return 32'sh80000000;
		else
			return v[COORD_W-1:0];
	endfunction

endpackage

// ===== sv/sphere_pair_contact_geometry_top.sv =====
// ----------------------------------------------------------------------------
// sphere_pair_contact_geometry_top
// Sphere pair contact test with unit normal, depth and contact point.
// ----------------------------------------------------------------------------
// Fully pipelined: one item enters per clock while no result waits at the output,
// and it passes through 5 front stages for differences, squares and the detection
// compare, 34 square root stages, 18 divider stages and 3 final stages. Latency
// is set by the bit-per-stage square root and divider. The whole pipeline holds
// while a result waits at the output; bubbles are not squeezed out.
module sphere_pair_contact_geometry_top (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [15:0]  cfg_wdata,
	input  logic         s_tvalid,
	output logic         s_tready,
	// first_x, first_y, first_z, second_x, second_y, second_z, radius_a, radius_b, pad
	input  logic [255:0] s_tdata,
	// already_linked
	input  logic [0:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// normal_x, normal_y, normal_z, contact_depth, point_x, point_y, point_z, pad
	output logic [183:0] m_tdata,
	// in_contact
	output logic [0:0]   m_tuser
);

	localparam int DivLat = spcg_pkg::QUOT_W;

	logic en;
	logic [15:0] factor_q;

	logic                          valid_s1;
	logic signed [2:0][31:0]       p1_s1;
	logic signed [2:0][32:0]       d_s1;
	logic [30:0]                   ra_s1, rb_s1;
	logic [31:0]                   rsum_s1;
	logic                          linked_s1;

	logic                          valid_s2;
	spcg_pkg::side_t               side_s2;
	logic [47:0]                   slim_s2;
	logic                          linked_s2;

	logic                          valid_s3;
	spcg_pkg::side_t               side_s3;
	logic [2:0][65:0]              sq_s3;
	logic [63:0]                   ll_s3;
	logic [47:0]                   hl_s3;
	logic [31:0]                   hh_s3;
	logic                          linked_s3;

	logic                          valid_s4;
	spcg_pkg::side_t               side_s4;
	logic [65:0]                   dsq_s4;
	logic [95:0]                   lim_s4;
	logic                          linked_s4;

	logic                          valid_s5;
	spcg_pkg::side_t               side_s5;
	logic [65:0]                   dsq_s5;

	logic                          sq_valid;
	logic [32:0]                   sq_root;
	spcg_pkg::side_t               sq_side;

	logic                          dv_s [0:DivLat];
	spcg_pkg::div_side_t           dl_s [0:DivLat];
	logic [2:0][16:0]              quot;

	logic                          valid_f1;
	logic signed [2:0][17:0]       n_f1;
	logic signed [35:0]            t2_f1;
	logic signed [31:0]            depth_f1;
	logic signed [2:0][31:0]       p1_f1;
	logic                          contact_f1;

	logic                          valid_f2;
	logic signed [2:0][53:0]       prod_f2;
	logic signed [2:0][17:0]       n_f2;
	logic signed [31:0]            depth_f2;
	logic signed [2:0][31:0]       p1_f2;
	logic                          contact_f2;

	logic                          valid_f3;
	logic [183:0]                  data_f3;
	logic                          contact_f3;

	assign en       = !valid_f3 || m_tready;
	assign s_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			factor_q <= spcg_pkg::FACTOR_RESET;
		else if (cfg_we)
			factor_q <= cfg_wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			for (int k = 0; k <= DivLat; k++)
				dv_s[k] <= 1'b0;
			valid_f1 <= 1'b0;
			valid_f2 <= 1'b0;
			valid_f3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= s_tvalid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			dv_s[0]  <= sq_valid;
			for (int k = 1; k <= DivLat; k++)
				dv_s[k] <= dv_s[k-1];
			valid_f1 <= dv_s[DivLat];
			valid_f2 <= valid_f1;
			valid_f3 <= valid_f2;
		end
	end

	always_ff @(posedge clk) begin
		spcg_pkg::side_t side_nx;
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				p1_s1[i] <= s_tdata[32*i +: 32];
				d_s1[i]  <= {s_tdata[32*(i+3)+31], s_tdata[32*(i+3) +: 32]}
					- {s_tdata[32*i+31], s_tdata[32*i +: 32]};
			end
			ra_s1     <= s_tdata[222:192];
			rb_s1     <= s_tdata[253:223];
			rsum_s1   <= {1'b0, s_tdata[222:192]} + {1'b0, s_tdata[253:223]};
			linked_s1 <= s_tuser[0];

			for (int i = 0; i < 3; i++) begin
				side_s2.p1[i]   <= p1_s1[i];
				side_s2.dneg[i] <= d_s1[i][32];
				side_s2.dmag[i] <= d_s1[i][32] ? 33'(-d_s1[i]) : 33'(d_s1[i]);
			end
			side_s2.ra      <= ra_s1;
			side_s2.rb      <= rb_s1;
			side_s2.contact <= 1'b0;
			slim_s2         <= 48'(factor_q) * 48'(rsum_s1);
			linked_s2       <= linked_s1;

			side_s3 <= side_s2;
			for (int i = 0; i < 3; i++)
				sq_s3[i] <= 66'(side_s2.dmag[i]) * 66'(side_s2.dmag[i]);
			ll_s3     <= 64'(slim_s2[31:0]) * 64'(slim_s2[31:0]);
			hl_s3     <= 48'(slim_s2[47:32]) * 48'(slim_s2[31:0]);
			hh_s3     <= 32'(slim_s2[47:32]) * 32'(slim_s2[47:32]);
			linked_s3 <= linked_s2;

			side_s4   <= side_s3;
			dsq_s4    <= sq_s3[0] + sq_s3[1] + sq_s3[2];
			lim_s4    <= ({hh_s3, 64'd0}) + ({15'd0, hl_s3, 33'd0}) + ({32'd0, ll_s3});
			linked_s4 <= linked_s3;

			side_nx         = side_s4;
			side_nx.contact = ({6'd0, dsq_s4, 24'd0} < lim_s4) || linked_s4;
			side_s5         <= side_nx;
			dsq_s5          <= dsq_s4;
		end
	end

	spcg_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (valid_s5),
		.in_rad    (dsq_s5),
		.in_side   (side_s5),
		.out_valid (sq_valid),
		.out_root  (sq_root),
		.out_side  (sq_side)
	);

	for (genvar gi = 0; gi < 3; gi++) begin : g_div
		spcg_div u_div (
			.clk    (clk),
			.en     (en),
			.in_mag (sq_side.dmag[gi]),
			.in_den (sq_root),
			.out_q  (quot[gi])
		);
	end

	always_ff @(posedge clk) begin
		logic signed [35:0] dep;
		if (en) begin
			dl_s[0].base <= sq_side;
			dl_s[0].sep  <= sq_root;
			for (int k = 1; k <= DivLat; k++)
				dl_s[k] <= dl_s[k-1];

			for (int i = 0; i < 3; i++) begin
				if (dl_s[DivLat].sep == '0)
					n_f1[i] <= '0;
				else if (dl_s[DivLat].base.dneg[i])
					n_f1[i] <= -$signed({1'b0, quot[i]});
				else
					n_f1[i] <= $signed({1'b0, quot[i]});
			end
			t2_f1 <= $signed({5'd0, dl_s[DivLat].base.ra}) - $signed({5'd0, dl_s[DivLat].base.rb})
				+ $signed({3'd0, dl_s[DivLat].sep});
			dep = $signed({4'd0, 32'({1'b0, dl_s[DivLat].base.ra} + {1'b0, dl_s[DivLat].base.rb})})
				- $signed({3'd0, dl_s[DivLat].sep});
			depth_f1   <= spcg_pkg::sat32(40'(dep));
			p1_f1      <= dl_s[DivLat].base.p1;
			contact_f1 <= dl_s[DivLat].base.contact;

			for (int i = 0; i < 3; i++)
				prod_f2[i] <= 54'(t2_f1) * 54'($signed(n_f1[i]));
			n_f2       <= n_f1;
			depth_f2   <= depth_f1;
			p1_f2      <= p1_f1;
			contact_f2 <= contact_f1;
		end
	end

	always_ff @(posedge clk) begin
		logic signed [39:0] sum;
		logic [183:0] word;
		if (en) begin
			word = '0;
			if (contact_f2) begin
				word[17:0]  = n_f2[0];
				word[35:18] = n_f2[1];
				word[53:36] = n_f2[2];
				word[85:54] = depth_f2;
				for (int i = 0; i < 3; i++) begin
					sum = 40'($signed(p1_f2[i])) + 40'($signed(prod_f2[i][53:17]));
					word[86 + 32*i +: 32] = spcg_pkg::sat32(sum);
				end
			end
			data_f3    <= word;
			contact_f3 <= contact_f2;
		end
	end

	assign m_tvalid   = valid_f3;
	assign m_tdata    = data_f3;
	assign m_tuser[0] = contact_f3;

	a_apart_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata == '0)
		else $error("non-contact item carries nonzero geometry");

	a_normal_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata[17:0]) <= 18'sd65536)
			&& ($signed(m_tdata[17:0]) >= -18'sd65536))
		else $error("normal x out of unit range");

	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> valid_s1)
		else $error("accepted item lost at first stage");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(valid_s5) && $stable(dv_s[DivLat]))
		else $error("pipeline moved during stall");

endmodule

// ===== sv/spcg_sqrt.sv =====
// ----------------------------------------------------------------------------
// spcg_sqrt
// Pipelined floor square root, one result bit per stage, with a side-band
// record that travels alongside.
// ----------------------------------------------------------------------------
module spcg_sqrt (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         in_valid,
	input  logic [spcg_pkg::DSQ_W-1:0]   in_rad,
	input  spcg_pkg::side_t              in_side,
	output logic                         out_valid,
	output logic [spcg_pkg::ROOT_W-1:0]  out_root,
	output spcg_pkg::side_t              out_side
);

	localparam int Steps = spcg_pkg::ROOT_W;
	localparam int RemW  = spcg_pkg::DSQ_W + 1;

	logic                          valid_s [0:Steps];
	logic [RemW-1:0]               rem_s   [0:Steps];
	logic [spcg_pkg::ROOT_W-1:0]   root_s  [0:Steps];
	spcg_pkg::side_t               side_s  [0:Steps];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= Steps; k++)
				valid_s[k] <= 1'b0;
		end else if (en) begin
			valid_s[0] <= in_valid;
			for (int k = 1; k <= Steps; k++)
				valid_s[k] <= valid_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		logic [RemW-1:0] trial;
		if (en) begin
			rem_s[0]  <= {1'b0, in_rad};
			root_s[0] <= '0;
			side_s[0] <= in_side;
			for (int k = 1; k <= Steps; k++) begin
				trial = ({{(RemW-spcg_pkg::ROOT_W){1'b0}}, root_s[k-1]} << (Steps - k + 1))
					+ ({{(RemW-1){1'b0}}, 1'b1} << (2 * (Steps - k)));
				side_s[k] <= side_s[k-1];
				if (rem_s[k-1] >= trial) begin
					rem_s[k]  <= rem_s[k-1] - trial;
					root_s[k] <= root_s[k-1]
						| ({{(spcg_pkg::ROOT_W-1){1'b0}}, 1'b1} << (Steps - k));
				end else begin
					rem_s[k]  <= rem_s[k-1];
					root_s[k] <= root_s[k-1];
				end
			end
		end
	end

	assign out_valid = valid_s[Steps];
	assign out_root  = root_s[Steps];
	assign out_side  = side_s[Steps];

endmodule

// ===== sv/spcg_div.sv =====
// ----------------------------------------------------------------------------
// spcg_div
// Pipelined restoring divider for one normal component: mag * 2^16 / den,
// one quotient bit per stage.
// ----------------------------------------------------------------------------
module spcg_div (
	input  logic                         clk,
	input  logic                         en,
	input  logic [spcg_pkg::DIFF_W-1:0]  in_mag,
	input  logic [spcg_pkg::ROOT_W-1:0]  in_den,
	output logic [spcg_pkg::QUOT_W-1:0]  out_q
);

	localparam int Steps = spcg_pkg::QUOT_W;
	localparam int RemW  = spcg_pkg::ROOT_W + Steps;

	logic [RemW-1:0]               rem_s [0:Steps];
	logic [spcg_pkg::ROOT_W-1:0]   den_s [0:Steps];
	logic [spcg_pkg::QUOT_W-1:0]   q_s   [0:Steps];

	always_ff @(posedge clk) begin
		logic [RemW-1:0] cmp;
		if (en) begin
			rem_s[0] <= {{(RemW-spcg_pkg::DIFF_W-16){1'b0}}, in_mag, 16'd0};
			den_s[0] <= in_den;
			q_s[0]   <= '0;
			for (int k = 1; k <= Steps; k++) begin
				cmp = {{(RemW-spcg_pkg::ROOT_W){1'b0}}, den_s[k-1]} << (Steps - k);
				den_s[k] <= den_s[k-1];
				if (rem_s[k-1] >= cmp) begin
					rem_s[k] <= rem_s[k-1] - cmp;
					q_s[k]   <= q_s[k-1] | ({{(Steps-1){1'b0}}, 1'b1} << (Steps - k));
				end else begin
					rem_s[k] <= rem_s[k-1];
					q_s[k]   <= q_s[k-1];
				end
			end
		end
	end

	assign out_q = q_s[Steps];

endmodule
